### hdl/mrtu_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the frame checker.
// No dependencies; the design modules and the testbench modules import this package.
package mrtu_pkg;

  localparam int MAX_FRAME = 256;
  localparam int CNT_W     = $clog2(MAX_FRAME + 2);

  localparam logic [CNT_W-1:0] CNT_SAT     = CNT_W'(MAX_FRAME + 1);
  localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] CNT_MIN     = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_ID      = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_FUNC    = CNT_W'(1);
  localparam logic [7:0]       PLEN_SAT    = 8'(MAX_FRAME - 4);

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] LEN_OK    = 2'd0;
  localparam logic [1:0] LEN_SHORT = 2'd1;
  localparam logic [1:0] LEN_LONG  = 2'd2;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       out_kind;
    logic [7:0] payload_byte;
    logic [7:0] unit_id;
    logic [7:0] function_code;
    logic       crc_ok;
    logic [1:0] length_status;
    logic [7:0] payload_length;
    logic       last;
  } mrtu_result_t;

  // Up to two results per processed byte, packed in order: en_b implies en_a.
  typedef struct packed {
    logic         en_a;
    logic         en_b;
    mrtu_result_t r0;
    mrtu_result_t r1;
  } mrtu_push_t;

  // Reflected CRC-16, one byte, bitwise over the eight shifts.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/mrtu_in_if.sv
// Byte request channel into the frame checker.
// Depends on nothing.
interface mrtu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

### hdl/mrtu_out_if.sv
// Result request channel out of the frame checker.
// Depends on nothing.
interface mrtu_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] payload_byte;
  logic [7:0] unit_id;
  logic [7:0] function_code;
  logic       crc_ok;
  logic [1:0] length_status;
  logic [7:0] payload_length;
  logic       last;

  modport source (output valid, output out_kind, output payload_byte, output unit_id,
                  output function_code, output crc_ok, output length_status,
                  output payload_length, output last, input ready);
  modport sink   (input valid, input out_kind, input payload_byte, input unit_id,
                  input function_code, input crc_ok, input length_status,
                  input payload_length, input last, output ready);
endinterface

### hdl/mrtu_frame.sv
// Input register, frame state (CRC, count, id, function, delay line) and result build.
// Depends on mrtu_pkg and mrtu_in_if.
module mrtu_frame import mrtu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mrtu_in_if.sink    rx,
  input  logic       space_ok,
  output mrtu_push_t push
);

  logic             stg_valid;
  logic [7:0]       stg_byte;
  logic             stg_eof;
  logic             go;

  logic [15:0]      crc_reg;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       id_reg;
  logic [7:0]       func_reg;
  logic [7:0]       delay_bytes [2];

  logic [15:0]      crc_next;
  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]       id_next;
  logic [7:0]       func_next;
  logic [CNT_W-1:0] plen_diff;
  logic             has_pay;
  mrtu_result_t     pay_res;
  mrtu_result_t     sum_res;

  assign go       = stg_valid && space_ok;
  assign rx.ready = !stg_valid || space_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      stg_valid <= 1'b1;
    end else if (go) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      stg_byte <= rx.rx_byte;
      stg_eof  <= rx.end_of_frame;
    end
  end

  always_comb begin
    crc_next  = crc_byte(crc_reg, stg_byte);
    id_next   = (byte_count == CNT_ID) ? stg_byte : id_reg;
    func_next = (byte_count == CNT_FUNC) ? stg_byte : func_reg;
    byte_count_next = (byte_count < CNT_SAT) ? byte_count + CNT_W'(1) : byte_count;
    has_pay   = byte_count >= CNT_MIN;
    plen_diff = byte_count_next - CNT_MIN;

    pay_res              = '0;
    pay_res.out_kind     = KIND_PAYLOAD;
    pay_res.payload_byte = delay_bytes[1];
    pay_res.last         = !stg_eof;

    sum_res               = '0;
    sum_res.out_kind      = KIND_SUMMARY;
    sum_res.unit_id       = id_next;
    sum_res.function_code = func_next;
    sum_res.crc_ok        = crc_next == 16'h0000;
    sum_res.last          = 1'b1;
    priority if (byte_count_next < CNT_MIN) begin
      sum_res.length_status  = LEN_SHORT;
      sum_res.payload_length = 8'h00;
    end else if (byte_count_next > CNT_MAX) begin
      sum_res.length_status  = LEN_LONG;
      sum_res.payload_length = PLEN_SAT;
    end else begin
      sum_res.length_status  = LEN_OK;
      sum_res.payload_length = 8'(plen_diff);
    end

    push.en_a = go && (has_pay || stg_eof);
    push.en_b = go && has_pay && stg_eof;
    push.r0   = has_pay ? pay_res : sum_res;
    push.r1   = sum_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= CRC_SEED;
      byte_count <= '0;
      id_reg     <= 8'h00;
      func_reg   <= 8'h00;
    end else if (go) begin
      if (stg_eof) begin
        crc_reg    <= CRC_SEED;
        byte_count <= '0;
        id_reg     <= 8'h00;
        func_reg   <= 8'h00;
      end else begin
        crc_reg    <= crc_next;
        byte_count <= byte_count_next;
        id_reg     <= id_next;
        func_reg   <= func_next;
      end
    end
  end

  // payload delay line, read only once four bytes of the frame have passed
  always_ff @(posedge clk) begin
    if (go) begin
      delay_bytes[1] <= delay_bytes[0];
      delay_bytes[0] <= stg_byte;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_SAT)
    else $error("byte count past saturation");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    go && stg_eof |=> byte_count == '0 && crc_reg == CRC_SEED)
    else $error("state not cleared after frame end");

  a_second_is_summary: assert property (@(posedge clk) disable iff (rst)
    push.en_b |-> push.en_a && push.r1.out_kind == KIND_SUMMARY
                  && push.r0.out_kind == KIND_PAYLOAD && !push.r0.last)
    else $error("bad result pair order");

endmodule

### hdl/mrtu_outq.sv
// Small result queue: takes up to two results a cycle, hands out one.
// Depends on mrtu_pkg and mrtu_out_if.
module mrtu_outq import mrtu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mrtu_push_t  push,
  output logic        space_ok,
  mrtu_out_if.source  res
);

  mrtu_result_t      q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              pop;
  mrtu_result_t      head;

  assign space_ok = count <= QCNT_W'(QDEPTH - 2);
  assign pop      = res.valid && res.ready;
  assign head     = q_mem[rd_ptr];

  assign count_next = count + QCNT_W'(push.en_a) + QCNT_W'(push.en_b) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.en_a) begin
      q_mem[wr_ptr] <= push.r0;
    end
    if (push.en_b) begin
      q_mem[QPTR_W'(wr_ptr + QPTR_W'(1))] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.en_a) + QPTR_W'(push.en_b);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  assign res.valid          = count != '0;
  assign res.out_kind       = head.out_kind;
  assign res.payload_byte   = head.payload_byte;
  assign res.unit_id        = head.unit_id;
  assign res.function_code  = head.function_code;
  assign res.crc_ok         = head.crc_ok;
  assign res.length_status  = head.length_status;
  assign res.payload_length = head.payload_length;
  assign res.last           = head.last;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.en_a |-> space_ok)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && !push.en_a |=> count == $past(count) - QCNT_W'(1))
    else $error("pop did not drain an entry");

endmodule

### hdl/modbus_rtu_frame_checker.sv
// Modbus RTU frame checker, top level.
// Depends on mrtu_pkg, mrtu_in_if, mrtu_out_if, mrtu_frame, mrtu_outq.
//
//   port  dir  carries
//   rx    in   rx_byte, end_of_frame (one frame byte per request)
//   res   out  out_kind, payload_byte, unit_id, function_code, crc_ok,
//              length_status, payload_length, last
//
// One byte accepted per cycle while rx.ready is high; the byte-wide CRC update
// sits between the input register and the result queue. A result passes the
// input register and the queue before it is valid on res. A frame-end byte
// with a payload result pushes two results into the 4-entry queue, which
// drains one per cycle while res.ready is high; rx.ready drops while the input
// register holds a byte and fewer than two slots are free.
// Synchronous reset clears frame state and the queue.
module modbus_rtu_frame_checker import mrtu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mrtu_in_if.sink    rx,
  mrtu_out_if.source res
);

  mrtu_push_t push;
  logic       space_ok;

  mrtu_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .space_ok (space_ok),
    .push     (push)
  );

  mrtu_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .res      (res)
  );

endmodule

### sim/mrtu_result_checker.sv
// Result checker for the Modbus RTU frame checker: watches both request channels,
// predicts payload and summary results per accepted byte, and compares them in order.
// Depends on mrtu_pkg, mrtu_in_if and mrtu_out_if.
module mrtu_result_checker import mrtu_pkg::*; (
  input  logic clk,
  input  logic rst,
  mrtu_in_if   rx,
  mrtu_out_if  res,
  output int   pending,
  output int   mismatches
);

  logic [15:0]      crc_acc;
  logic [CNT_W-1:0] byte_idx;
  logic [7:0]       uid_seen;
  logic [7:0]       fc_seen;
  logic [7:0]       lag1;
  logic [7:0]       lag2;
  mrtu_result_t     due_results[$];
  int               fail_cnt = 0;

  assign mismatches = fail_cnt;

  // bit-serial reflected CRC, LSB first
  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic clear_frame();
    crc_acc  = CRC_SEED;
    byte_idx = '0;
    uid_seen = '0;
    fc_seen  = '0;
    lag1     = '0;
    lag2     = '0;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic eof);
    mrtu_result_t     r;
    logic [CNT_W-1:0] idx;
    idx     = byte_idx;
    crc_acc = crc16_next(crc_acc, b);
    if (idx == CNT_ID) begin
      uid_seen = b;
    end else if (idx == CNT_FUNC) begin
      fc_seen = b;
    end
    // payload leaves two bytes late, so the CRC bytes never show up
    if (idx >= CNT_MIN) begin
      r              = '0;
      r.out_kind     = KIND_PAYLOAD;
      r.payload_byte = lag2;
      r.last         = !eof;
      due_results.push_back(r);
    end
    lag2 = lag1;
    lag1 = b;
    if (byte_idx < CNT_SAT) begin
      byte_idx++;
    end
    if (eof) begin
      r               = '0;
      r.out_kind      = KIND_SUMMARY;
      r.unit_id       = uid_seen;
      r.function_code = fc_seen;
      r.crc_ok        = (crc_acc == 16'h0000);
      r.last          = 1'b1;
      if (byte_idx < CNT_MIN) begin
        r.length_status = LEN_SHORT;
      end else if (byte_idx > CNT_MAX) begin
        r.length_status  = LEN_LONG;
        r.payload_length = PLEN_SAT;
      end else begin
        r.length_status  = LEN_OK;
        r.payload_length = 8'(byte_idx - CNT_MIN);
      end
      due_results.push_back(r);
      clear_frame();
    end
  endtask

  always @(posedge clk) begin : watch
    mrtu_result_t want;
    if (rst) begin
      clear_frame();
      due_results.delete();
    end else begin
      if (rx.valid && rx.ready) begin
        take_byte(rx.rx_byte, rx.end_of_frame);
      end
      if (res.valid && res.ready) begin
        if (due_results.size() == 0) begin
          report("result arrived with none outstanding");
        end else begin
          want = due_results.pop_front();
          check_field("out_kind", 8'(res.out_kind), 8'(want.out_kind));
          check_field("payload_byte", res.payload_byte, want.payload_byte);
          check_field("unit_id", res.unit_id, want.unit_id);
          check_field("function_code", res.function_code, want.function_code);
          check_field("crc_ok", 8'(res.crc_ok), 8'(want.crc_ok));
          check_field("length_status", 8'(res.length_status), 8'(want.length_status));
          check_field("payload_length", res.payload_length, want.payload_length);
          check_field("last", 8'(res.last), 8'(want.last));
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

### sim/tb.sv
// Top of the frame checker testbench: clock, reset, frame stimulus and result-side
// stalls; the verdict comes from mrtu_result_checker.
// Depends on mrtu_pkg, mrtu_in_if, mrtu_out_if, modbus_rtu_frame_checker, mrtu_result_checker.
module tb;
  import mrtu_pkg::*;

  logic clk = 1'b0;
  logic rst;
  int   pending;
  int   mismatches;

  logic [7:0] frame_q[$];
  int         bytes_sent = 0;
  int         hold_ticket = 0;
  logic       calm = 1'b0;
  logic       quiet_frame;

  mrtu_in_if  rx_ch();
  mrtu_out_if res_ch();

  modbus_rtu_frame_checker DUT (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  mrtu_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .res        (res_ch),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // append CRC-16/MODBUS, low byte first
  task automatic seal_frame();
    logic [15:0] c;
    logic        fb;
    c = CRC_SEED;
    foreach (frame_q[k]) begin
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ frame_q[k][i];
        c  = c >> 1;
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
    end
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (!calm && !quiet_frame && $urandom_range(0, 9) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    rx_ch.valid        <= 1'b1;
    rx_ch.rx_byte      <= b;
    rx_ch.end_of_frame <= eof;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    quiet_frame = ($urandom_range(0, 9) < 3);
    foreach (frame_q[i]) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  task automatic fill_frame(input int plen);
    frame_q = {};
    frame_q.push_back(8'($urandom_range(0, 255)));
    frame_q.push_back(8'($urandom_range(0, 255)));
    repeat (plen) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // result side: random stall bursts, plus one long hold per ticket
  initial begin
    int hold;
    int seen;
    hold = 0;
    seen = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (seen != hold_ticket) begin
        seen = hold_ticket;
        hold = 120;
      end else if (hold == 0 && !calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 18);
      end
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int frames;
    int pick;
    int pos;
    rst                = 1'b1;
    rx_ch.valid        = 1'b0;
    rx_ch.rx_byte      = '0;
    rx_ch.end_of_frame = 1'b0;
    quiet_frame        = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short frames: one, two and three bytes
    frame_q = {8'hFF};
    send_frame();
    frame_q = {8'h00, 8'hFF};
    send_frame();
    frame_q = {8'h12, 8'h34, 8'h56};
    send_frame();
    // minimum frame, no payload
    frame_q = {8'hFF, 8'h00};
    seal_frame();
    send_frame();
    // extreme id/function and payload bytes
    frame_q = {8'h00, 8'hFF, 8'h00, 8'hFF};
    seal_frame();
    send_frame();
    // corrupted payload byte, so the CRC check fails
    frame_q = {8'h55, 8'h03, 8'hAA};
    seal_frame();
    frame_q[2] ^= 8'h01;
    send_frame();

    frames = 0;
    while (bytes_sent < 950) begin
      if (frames == 5) begin
        fill_frame(MAX_FRAME - 4);       // exactly the maximum length
        seal_frame();
      end else if (frames == 15) begin
        fill_frame(MAX_FRAME + 2);       // over the maximum, count saturates
        seal_frame();
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          fill_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                 : $urandom_range(0, 12));
          seal_frame();
        end else if (pick == 7) begin
          fill_frame($urandom_range(0, 12));
          seal_frame();
          pos = $urandom_range(0, frame_q.size() - 1);
          frame_q[pos] ^= 8'(1 << $urandom_range(0, 7));
        end else if (pick == 8) begin
          fill_frame(0);
          frame_q = frame_q[0:$urandom_range(0, 1)];
          if ($urandom_range(0, 1) == 1) begin
            frame_q.push_back(8'($urandom_range(0, 255)));
          end
        end else begin
          fill_frame($urandom_range(2, 10));   // random noise, CRC almost surely bad
        end
      end
      if (frames == 8) begin
        hold_ticket <= hold_ticket + 1;
      end
      if (frames == 12) begin
        rx_ch.valid <= 1'b0;
        wait_drained();
      end
      calm <= (bytes_sent > 800);
      send_frame();
      frames++;
    end
    rx_ch.valid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
